FILE: sv/aesrr_pkg.sv
package aesrr_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [7:0] byte_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [WORD_W-1:0] word_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW     = 2'd0,
    REG_KEY_HIGH    = 2'd1,
    REG_ROUND_COUNT = 2'd2,
    REG_CIPHER_MODE = 2'd3
  } reg_idx_t;

  // cipher modes
  typedef enum logic [1:0] {
    MODE_STD   = 2'd0,
    MODE_MIX   = 2'd1,
    MODE_SBOX  = 2'd2,
    MODE_DECRY = 2'd3
  } mode_t;

  // round unit operation
  typedef enum logic [2:0] {
    OP_ARK   = 3'd0,  // key addition only
    OP_ENC   = 3'd1,  // sub, shift, mix, key
    OP_ENCL  = 3'd2,  // sub, shift, key
    OP_SUB   = 3'd3,  // sub only
    OP_DEC   = 3'd4,  // invshift, invsub, key, invmix
    OP_DECL  = 3'd5,  // invshift, invsub, key
    OP_PASS  = 3'd6   // unchanged
  } op_t;

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(byte_t a, byte_t b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic byte_t ginv(byte_t x);
    byte_t r;
    byte_t b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    return r;
  endfunction

  function automatic byte_t rotl(byte_t b, int s);
    return byte_t'((b << s) | (b >> (8 - s)));
  endfunction

  function automatic byte_t sbox_calc(byte_t x);
    byte_t b;
    b = ginv(x);
    return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox_calc(byte_t x);
    return ginv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ 8'h05);
  endfunction

  typedef byte_t sbox_tbl_t [256];

  function automatic sbox_tbl_t make_sbox(bit inverse);
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? inv_sbox_calc(byte_t'(i)) : sbox_calc(byte_t'(i));
    end
    return t;
  endfunction

  localparam sbox_tbl_t SBOX     = make_sbox(1'b0);
  localparam sbox_tbl_t INV_SBOX = make_sbox(1'b1);

endpackage

FILE: sv/aesrr_stream_if.sv
interface aesrr_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] low;
  logic [63:0] high;
  modport source (output valid, output low, output high, input ready);
  modport sink (input valid, input low, input high, output ready);
endinterface

FILE: sv/aesrr_round.sv
module aesrr_round (
  input  aesrr_pkg::op_t    op,
  input  aesrr_pkg::block_t state_in,
  input  aesrr_pkg::block_t rkey,
  output aesrr_pkg::block_t state_out
);

  aesrr_pkg::byte_t s [16];
  aesrr_pkg::byte_t a [16];
  aesrr_pkg::byte_t b [16];
  aesrr_pkg::byte_t k [16];
  aesrr_pkg::byte_t sub [16];
  aesrr_pkg::byte_t shf [16];
  aesrr_pkg::byte_t mix [16];
  aesrr_pkg::byte_t isf [16];
  aesrr_pkg::byte_t isb [16];
  aesrr_pkg::byte_t dk [16];
  aesrr_pkg::byte_t imx [16];
  aesrr_pkg::byte_t r [16];

  // key bytes: word c byte j at bits 127-32c-8j
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[8*i +: 8];
      k[i] = rkey[127 - 8*i -: 8];
      sub[i] = aesrr_pkg::SBOX[s[i]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        shf[4*c + w] = sub[4*((c + w) % 4) + w];
        isf[4*((c + w) % 4) + w] = s[4*c + w];
      end
    end
    for (int i = 0; i < 16; i++) begin
      isb[i] = aesrr_pkg::INV_SBOX[isf[i]];
      dk[i] = isb[i] ^ k[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        a[4*c + w] = shf[4*c + w];
        b[4*c + w] = dk[4*c + w];
      end
      for (int w = 0; w < 4; w++) begin
        mix[4*c + w] = aesrr_pkg::xtime(a[4*c + w])
          ^ aesrr_pkg::xtime(a[4*c + (w+1)%4]) ^ a[4*c + (w+1)%4]
          ^ a[4*c + (w+2)%4] ^ a[4*c + (w+3)%4];
        imx[4*c + w] = aesrr_pkg::gmul(b[4*c + w], 8'h0e)
          ^ aesrr_pkg::gmul(b[4*c + (w+1)%4], 8'h0b)
          ^ aesrr_pkg::gmul(b[4*c + (w+2)%4], 8'h0d)
          ^ aesrr_pkg::gmul(b[4*c + (w+3)%4], 8'h09);
      end
    end
    for (int i = 0; i < 16; i++) begin
      case (op)
        aesrr_pkg::OP_ARK:  r[i] = s[i] ^ k[i];
        aesrr_pkg::OP_ENC:  r[i] = mix[i] ^ k[i];
        aesrr_pkg::OP_ENCL: r[i] = shf[i] ^ k[i];
        aesrr_pkg::OP_SUB:  r[i] = sub[i];
        aesrr_pkg::OP_DEC:  r[i] = imx[i];
        aesrr_pkg::OP_DECL: r[i] = dk[i];
        default:            r[i] = s[i];
      endcase
      state_out[8*i +: 8] = r[i];
    end
  end

endmodule

FILE: sv/aes128_round_reduced_cipher_top.sv
// channel  dir  payload                       handshake
// in       in   in_ch.low, in_ch.high         in_ch.valid / in_ch.ready
// out      out  out_ch.low, out_ch.high       out_ch.valid / out_ch.ready
// cfg      in   cfg_index, cfg_data (64 bits) cfg_we
//
// a key write runs the key expansion: four key words copied and then 40 schedule words,
//   one word a cycle into the round-key memory while no register write comes in; requests wait
// each step fetches its four round-key words one a cycle, while no register write comes in,
//   from the memory, whose read is registered, and then runs the round; a block takes 1 to 11
//   steps (11 for decrypt), with the request taken in the idle state and the result held
//   in the output state until it is taken
// rst_n synchronous, active low; resets control state and the configuration registers
// the result register holds under a stall; a new request waits until taken
module aes128_round_reduced_cipher_top #(
  parameter int unsigned FULL_ROUNDS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  aesrr_stream_if.sink           in_ch,
  aesrr_stream_if.source         out_ch,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data
);

  localparam int unsigned KEY_WORDS = 4 * (FULL_ROUNDS + 1);
  localparam int unsigned KA_W = $clog2(KEY_WORDS);
  localparam int unsigned RND_W = $clog2(FULL_ROUNDS + 2);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXP  = 6'b000010,
    ST_READ = 6'b000100,
    ST_RUN  = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_INIT = 6'b100000
  } state_t;

  state_t              st_r, st_nxt;
  logic [63:0]         key_low_r, key_high_r;
  logic [3:0]          round_count_r;
  aesrr_pkg::mode_t    mode_r;
  logic                keys_ready_r;

  // round-key memory
  aesrr_pkg::word_t    rk_mem [KEY_WORDS];
  aesrr_pkg::word_t    rk_rd_r;
  logic [KA_W-1:0]     rd_addr;
  logic                wr_en;
  logic [KA_W-1:0]     wr_addr;
  aesrr_pkg::word_t    wr_data;

  // key expansion: last four words kept in a window
  aesrr_pkg::word_t    win_r [4];
  logic [KA_W-1:0]     exp_idx_r;
  logic [7:0]          rcon_r;
  aesrr_pkg::word_t    t_rot, t_sub, exp_word;

  // block work
  aesrr_pkg::block_t   blk_r, blk_nxt, rk_blk_r;
  logic [RND_W-1:0]    step_r;     // current step number
  logic [RND_W-1:0]    last_r;     // final step number
  logic [1:0]          wsel_r;     // word being fetched
  logic                rd_pend_r;
  aesrr_pkg::op_t      op;
  logic [RND_W-1:0]    rkey_idx;
  logic [3:0]          n_sat;

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_addr] <= wr_data;
    rk_rd_r <= rk_mem[rd_addr];
  end

  assign n_sat = (round_count_r > 4'(FULL_ROUNDS)) ? 4'(FULL_ROUNDS) : round_count_r;

  // schedule word for exp_idx_r
  assign t_rot = {win_r[3][23:0], win_r[3][31:24]};
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      t_sub[8*j +: 8] = aesrr_pkg::SBOX[t_rot[8*j +: 8]];
    end
    if (exp_idx_r[1:0] == 2'd0) begin
      exp_word = win_r[0] ^ t_sub ^ {rcon_r, 24'h0};
    end else begin
      exp_word = win_r[0] ^ win_r[3];
    end
  end

  // op of the current step; step 0 is the first key addition
  always_comb begin
    op = aesrr_pkg::OP_PASS;
    rkey_idx = step_r;
    if (mode_r == aesrr_pkg::MODE_DECRY) begin
      rkey_idx = RND_W'(FULL_ROUNDS) - step_r;
      if (step_r == '0) op = aesrr_pkg::OP_ARK;
      else if (step_r == last_r) op = aesrr_pkg::OP_DECL;
      else op = aesrr_pkg::OP_DEC;
    end else if (step_r == '0) begin
      op = aesrr_pkg::OP_ARK;
    end else if (step_r != last_r) begin
      op = aesrr_pkg::OP_ENC;
    end else begin
      case (mode_r)
        aesrr_pkg::MODE_STD: op = aesrr_pkg::OP_ENCL;
        aesrr_pkg::MODE_MIX: op = aesrr_pkg::OP_ENC;
        aesrr_pkg::MODE_SBOX: op = aesrr_pkg::OP_SUB;
        default: op = aesrr_pkg::OP_PASS;
      endcase
      // zero rounds in standard mode reuses key 0
      if (mode_r == aesrr_pkg::MODE_STD && n_sat == 4'd0) rkey_idx = '0;
    end
  end

  aesrr_round u_round (
    .op        (op),
    .state_in  (blk_r),
    .rkey      (rk_blk_r),
    .state_out (blk_nxt)
  );

  always_comb begin
    rd_addr = KA_W'({rkey_idx, 2'b00}) + KA_W'(wsel_r);
    wr_en = 1'b0;
    wr_addr = exp_idx_r;
    wr_data = exp_word;
    if (st_r == ST_INIT) begin
      wr_en = 1'b1;
      wr_data = win_r[exp_idx_r[1:0]];
    end else if (st_r == ST_EXP) begin
      wr_en = 1'b1;
    end
  end

  assign in_ch.ready  = (st_r == ST_IDLE) && !cfg_we;
  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.low   = blk_r[63:0];
  assign out_ch.high  = blk_r[127:64];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_ch.valid && in_ch.ready) st_nxt = ST_READ;
      ST_INIT: if (exp_idx_r == KA_W'(3)) st_nxt = ST_EXP;
      ST_EXP:  if (exp_idx_r == KA_W'(KEY_WORDS - 1)) st_nxt = ST_IDLE;
      ST_READ: if (rd_pend_r && wsel_r == 2'd0) st_nxt = ST_RUN;
      ST_RUN:  st_nxt = (step_r == last_r) ? ST_OUT : ST_READ;
      ST_OUT:  if (out_ch.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_we && (cfg_index == aesrr_pkg::REG_KEY_LOW || cfg_index == aesrr_pkg::REG_KEY_HIGH))
      st_nxt = ST_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      key_low_r <= '0;
      key_high_r <= '0;
      round_count_r <= 4'(FULL_ROUNDS);
      mode_r <= aesrr_pkg::MODE_STD;
      keys_ready_r <= 1'b0;
      exp_idx_r <= '0;
      wsel_r <= '0;
      rd_pend_r <= 1'b0;
      step_r <= '0;
      last_r <= '0;
      rcon_r <= 8'h01;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          aesrr_pkg::REG_KEY_LOW: begin
            key_low_r <= cfg_data;
            win_r[0] <= {cfg_data[7:0], cfg_data[15:8], cfg_data[23:16], cfg_data[31:24]};
            win_r[1] <= {cfg_data[39:32], cfg_data[47:40], cfg_data[55:48], cfg_data[63:56]};
            win_r[2] <= {key_high_r[7:0], key_high_r[15:8], key_high_r[23:16], key_high_r[31:24]};
            win_r[3] <= {key_high_r[39:32], key_high_r[47:40], key_high_r[55:48],
                         key_high_r[63:56]};
          end
          aesrr_pkg::REG_KEY_HIGH: begin
            key_high_r <= cfg_data;
            win_r[0] <= {key_low_r[7:0], key_low_r[15:8], key_low_r[23:16], key_low_r[31:24]};
            win_r[1] <= {key_low_r[39:32], key_low_r[47:40], key_low_r[55:48],
                         key_low_r[63:56]};
            win_r[2] <= {cfg_data[7:0], cfg_data[15:8], cfg_data[23:16], cfg_data[31:24]};
            win_r[3] <= {cfg_data[39:32], cfg_data[47:40], cfg_data[55:48], cfg_data[63:56]};
          end
          aesrr_pkg::REG_ROUND_COUNT: round_count_r <= cfg_data[3:0];
          default: mode_r <= aesrr_pkg::mode_t'(cfg_data[1:0]);
        endcase
        if (cfg_index == aesrr_pkg::REG_KEY_LOW || cfg_index == aesrr_pkg::REG_KEY_HIGH) begin
          exp_idx_r <= '0;
          rcon_r <= 8'h01;
          keys_ready_r <= 1'b1;
        end
      end else begin
        case (st_r)
          ST_INIT: exp_idx_r <= exp_idx_r + KA_W'(1);
          ST_EXP: begin
            exp_idx_r <= exp_idx_r + KA_W'(1);
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
            win_r[2] <= win_r[3];
            win_r[3] <= exp_word;
            if (exp_idx_r[1:0] == 2'd0) rcon_r <= aesrr_pkg::xtime(rcon_r);
          end
          ST_IDLE: if (in_ch.valid && in_ch.ready) begin
            blk_r <= {in_ch.high, in_ch.low};
            step_r <= '0;
            wsel_r <= '0;
            rd_pend_r <= 1'b0;
            // in standard and S-box modes, zero rounds still needs a final step after the first key addition
            if (mode_r == aesrr_pkg::MODE_DECRY)
              last_r <= RND_W'(FULL_ROUNDS);
            else if (mode_r == aesrr_pkg::MODE_MIX)
              last_r <= RND_W'(n_sat);
            else
              last_r <= (n_sat == 4'd0) ? RND_W'(1) : RND_W'(n_sat);
          end
          ST_READ: begin
            wsel_r <= wsel_r + 2'd1;
            rd_pend_r <= 1'b1;
            if (rd_pend_r)
              rk_blk_r <= {rk_blk_r[95:0], rk_rd_r};
            if (rd_pend_r && wsel_r == 2'd0) rd_pend_r <= 1'b0;
          end
          ST_RUN: begin
            // mode 1 with zero rounds: last step is step 0, which passes
            if (!(mode_r == aesrr_pkg::MODE_MIX && last_r == '0))
              blk_r <= blk_nxt;
            step_r <= step_r + RND_W'(1);
            wsel_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // a request is only taken when idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> st_r == ST_READ)
    else $error("request not started");
  // result holds while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready && !cfg_we) |=> out_ch.valid && $stable(blk_r))
    else $error("result changed under stall");
  // step never passes the last one
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> step_r <= last_r)
    else $error("step overrun");
  // expansion writes stay in the memory
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_addr < KA_W'(KEY_WORDS))
    else $error("key write out of range");
  // requests only once keys exist: a rule for the user, which the block itself does not enforce
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> keys_ready_r)
    else $error("run without keys");

endmodule

FILE: sim/aesrr_cipher_checker.sv
module aesrr_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  aesrr_stream_if     in_mon,
  aesrr_stream_if     out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } block_pair_t;

  logic [63:0]         key_lo, key_hi;
  logic [3:0]          rounds;
  aesrr_pkg::mode_t    mode;
  aesrr_pkg::word_t    sched [44];
  aesrr_pkg::byte_t    fwd_sub [256];
  aesrr_pkg::byte_t    inv_sub [256];
  aesrr_pkg::byte_t    st [16];
  block_pair_t         expected_q [$];

  function automatic aesrr_pkg::byte_t gf_double(aesrr_pkg::byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aesrr_pkg::byte_t gf_product(aesrr_pkg::byte_t a, aesrr_pkg::byte_t b);
    aesrr_pkg::byte_t acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  function automatic aesrr_pkg::byte_t rot8(aesrr_pkg::byte_t b, int n);
    return aesrr_pkg::byte_t'((b << n) | (b >> (8 - n)));
  endfunction

  initial begin
    aesrr_pkg::byte_t b;
    for (int x = 0; x < 256; x++) begin
      b = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_product(aesrr_pkg::byte_t'(x), aesrr_pkg::byte_t'(y)) == 8'h01)
          b = aesrr_pkg::byte_t'(y);
      fwd_sub[x] = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = aesrr_pkg::byte_t'(x);
  end

  function automatic void expand_schedule();
    aesrr_pkg::word_t t;
    aesrr_pkg::byte_t rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      t = 32'h0;
      for (int j = 0; j < 4; j++)
        t[31-8*j -: 8] = (i < 2) ? key_lo[8*(4*i+j) +: 8] : key_hi[8*(4*(i-2)+j) +: 8];
      sched[i] = t;
    end
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        for (int j = 0; j < 4; j++) t[8*j +: 8] = fwd_sub[t[8*j +: 8]];
        t[31:24] ^= rc;
        rc = gf_double(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  function automatic void add_key(int r);
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) st[4*c+j] ^= sched[4*r+c][31-8*j -: 8];
  endfunction

  function automatic void sub_all(bit inverse);
    for (int i = 0; i < 16; i++) st[i] = inverse ? inv_sub[st[i]] : fwd_sub[st[i]];
  endfunction

  function automatic void shift_all(bit inverse);
    aesrr_pkg::byte_t t [16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inverse) t[4*((c+r)%4)+r] = st[4*c+r];
        else t[4*c+r] = st[4*((c+r)%4)+r];
    st = t;
  endfunction

  function automatic void mix_all(bit inverse);
    aesrr_pkg::byte_t a [4];
    aesrr_pkg::byte_t coef [4];
    aesrr_pkg::byte_t v;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = st[4*c+k];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_product(a[k], coef[(k+4-r)%4]);
        st[4*c+r] = v;
      end
    end
  endfunction

  function automatic void enc_round(int r);
    sub_all(1'b0);
    shift_all(1'b0);
    mix_all(1'b0);
    add_key(r);
  endfunction

  function automatic block_pair_t cipher_block(logic [63:0] lo, logic [63:0] hi);
    block_pair_t res;
    int n;
    n = (rounds > 10) ? 10 : int'(rounds);
    for (int i = 0; i < 8; i++) begin
      st[i]   = lo[8*i +: 8];
      st[8+i] = hi[8*i +: 8];
    end
    case (mode)
      aesrr_pkg::MODE_STD: begin
        add_key(0);
        for (int i = 1; i < n; i++) enc_round(i);
        sub_all(1'b0);
        shift_all(1'b0);
        add_key(n);
      end
      aesrr_pkg::MODE_MIX: begin
        if (n != 0) begin
          add_key(0);
          for (int i = 1; i <= n; i++) enc_round(i);
        end
      end
      aesrr_pkg::MODE_SBOX: begin
        add_key(0);
        for (int i = 1; i < n; i++) enc_round(i);
        sub_all(1'b0);
      end
      default: begin
        add_key(10);
        for (int i = 9; i >= 1; i--) begin
          shift_all(1'b1);
          sub_all(1'b1);
          add_key(i);
          mix_all(1'b1);
        end
        shift_all(1'b1);
        sub_all(1'b1);
        add_key(0);
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      res.lo[8*i +: 8] = st[i];
      res.hi[8*i +: 8] = st[8+i];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    block_pair_t exp_res;
    if (!rst_n) begin
      key_lo = '0;
      key_hi = '0;
      rounds = 4'd10;
      mode = aesrr_pkg::MODE_STD;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (aesrr_pkg::reg_idx_t'(cfg_index))
          aesrr_pkg::REG_KEY_LOW:     begin key_lo = cfg_data; expand_schedule(); end
          aesrr_pkg::REG_KEY_HIGH:    begin key_hi = cfg_data; expand_schedule(); end
          aesrr_pkg::REG_ROUND_COUNT: rounds = cfg_data[3:0];
          aesrr_pkg::REG_CIPHER_MODE: mode = aesrr_pkg::mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(cipher_block(in_mon.low, in_mon.high));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result low %h high %h", out_mon.low, out_mon.high);
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_mon.low !== exp_res.lo) begin
            $error("result_low expected %h actual %h", exp_res.lo, out_mon.low);
            fail_count++;
          end
          if (out_mon.high !== exp_res.hi) begin
            $error("result_high expected %h actual %h", exp_res.hi, out_mon.high);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycles;

  // receiver control: calm turns off random idling (also on the sender), hold_tog starts a long hold-off
  bit          calm;
  bit          hold_tog;
  bit          hold_seen;
  int          hold_cnt;

  aesrr_stream_if in_ch ();
  aesrr_stream_if out_ch ();

  aes128_round_reduced_cipher_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  aesrr_cipher_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long counted hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_seen = 1'b0;
    hold_cnt = 0;
  end
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= 600;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 6);
    end
  end

  // register write, then enough quiet cycles for the key expansion to finish
  task automatic write_reg(aesrr_pkg::reg_idx_t idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (45) @(posedge clk);
  endtask

  // drain every outstanding result, then let the block go fully idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic send_request(logic [63:0] lo, logic [63:0] hi);
    while (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.low <= lo;
    in_ch.high <= hi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic set_mode(aesrr_pkg::mode_t m, logic [3:0] n);
    drain();
    write_reg(aesrr_pkg::REG_CIPHER_MODE, 64'(m));
    write_reg(aesrr_pkg::REG_ROUND_COUNT, {$urandom, 28'($urandom), n});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_field();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0]      pat_lo [3];
    logic [63:0]      pat_hi [3];
    logic [3:0]       rc_set [3];
    aesrr_pkg::mode_t m;
    logic [3:0]       n;
    int               k;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.low = '0;
    in_ch.high = '0;
    calm = 1'b0;
    hold_tog = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // known-answer key and plaintext, checked first with reset settings
    write_reg(aesrr_pkg::REG_KEY_LOW, 64'h0706050403020100);
    write_reg(aesrr_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    send_request(64'h7766554433221100, 64'hffeeddccbbaa9988);
    send_request('0, '0);

    // each encrypt mode against zero, one and saturated round counts
    pat_lo = '{64'h0, '1, 64'h7766554433221100};
    pat_hi = '{64'h0, '1, 64'hffeeddccbbaa9988};
    rc_set = '{4'd0, 4'd1, 4'd15};
    k = 0;
    for (int mi = 0; mi < 3; mi++) begin
      for (int ri = 0; ri < 3; ri++) begin
        set_mode(aesrr_pkg::mode_t'(mi), rc_set[ri]);
        send_request(pat_lo[k % 3], pat_hi[k % 3]);
        k++;
      end
    end
    // decrypt ignores the round count, so set it to something odd on purpose
    set_mode(aesrr_pkg::MODE_DECRY, 4'd3);
    send_request(64'h0, 64'h0);
    send_request('1, '1);
    send_request(64'h7766554433221100, 64'hffeeddccbbaa9988);

    // random phases: new settings each time, sometimes a new key
    for (int ph = 0; ph < 12; ph++) begin
      m = aesrr_pkg::mode_t'($urandom_range(3));
      case ($urandom_range(4))
        0: n = 4'd0;
        1: n = 4'd10;
        2: n = 4'd15;
        default: n = 4'($urandom_range(15));
      endcase
      set_mode(m, n);
      if ($urandom_range(2) != 0) write_reg(aesrr_pkg::REG_KEY_LOW, rand_field());
      if ($urandom_range(2) != 0) write_reg(aesrr_pkg::REG_KEY_HIGH, rand_field());
      calm = (ph == 4);
      for (int i = 0; i < 37; i++) begin
        // long result hold-off while requests keep coming, so the block backs up
        if (ph == 2 && i == 5) hold_tog = ~hold_tog;
        // sender pause until everything in flight has come back
        if (ph == 7 && i == 18) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_request(rand_field(), rand_field());
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/aesrr_pkg.sv
sv/aesrr_stream_if.sv
sv/aesrr_round.sv
sv/aes128_round_reduced_cipher_top.sv
sim/aesrr_cipher_checker.sv
sim/testbench.sv
